>>> src/bhpq_pkg.sv
// Package: operation, status and sequencer state codes for the heap queue.
package bhpq_pkg;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_POP    = 2'd1;
   localparam logic [1:0] KIND_UPDATE = 2'd2;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_EMPTY     = 2'd1;
   localparam logic [1:0] STAT_FULL      = 2'd2;
   localparam logic [1:0] STAT_BAD_INDEX = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_POP_ROOT,
      S_POP_LAST,
      S_UPD,
      S_UP,
      S_UP_CMP,
      S_DOWN,
      S_DOWN_L,
      S_DOWN_R,
      S_TOP,
      S_OUT
   } state_type;

endpackage

>>> src/bhpq_if.sv
// Interfaces: request and response channels of the heap queue.
interface bhpq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] key;
   logic [31:0] value;
   logic [7:0]  index;
   modport source (output valid, kind, key, value, index, input ready);
   modport sink (input valid, kind, key, value, index, output ready);
endinterface

interface bhpq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] popped_key;
   logic [31:0] popped_value;
   logic [31:0] top_key;
   logic [31:0] top_value;
   logic [8:0]  entry_count;
   logic        is_empty;
   modport source (output valid, status, popped_key, popped_value, top_key, top_value,
                   entry_count, is_empty, input ready);
   modport sink (input valid, status, popped_key, popped_value, top_key, top_value,
                 entry_count, is_empty, output ready);
endinterface

>>> src/bhpq_ram.sv
// Generic RAM: one write port, one read port with registered read data.
module bhpq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

>>> src/binary_heap_priority_queue.sv
// Insert and upward update walk the heap up level by level, pop and downward update walk it
// down level by level; each transaction ends with a root readback for the response.
// Throughput: one transaction at a time; the single read port of the heap RAM sets it.
// A finished response waits in the output register while the next request is accepted.
// Reset (synchronous): count cleared to zero, order mode min-heap, no response pending.
// Heap RAM contents are not cleared; only entries below the count are ever read.
module binary_heap_priority_queue #(
   parameter int CAPACITY   = 256,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic csr_wdata,
   bhpq_req_if.sink   req,
   bhpq_rsp_if.source rsp
);
   import bhpq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (AW + 3 > 10) ? AW + 3 : 10;
   localparam int EW = KEY_BITS + VALUE_BITS;
   localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

   state_type state_ff, state_in;
   logic                  mode_ff;
   logic [CW-1:0]         n_ff, n_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic [KEY_BITS-1:0]   ekey_ff, ekey_in, lkey_ff, lkey_in;
   logic [VALUE_BITS-1:0] eval_ff, eval_in, lval_ff, lval_in;
   logic [1:0]            status_ff, status_in;
   logic [31:0]           pk_ff, pk_in, pv_ff, pv_in;
   logic                  rvalid_ff, rvalid_in;
   logic [1:0]            rstatus_ff, rstatus_in;
   logic [31:0]           rpk_ff, rpk_in, rpv_ff, rpv_in, rtk_ff, rtk_in, rtv_ff, rtv_in;
   logic [8:0]            rcnt_ff, rcnt_in;
   logic                  rempty_ff, rempty_in;

   logic                  we;
   logic [AW-1:0]         waddr, raddr;
   logic [EW-1:0]         wdata, rdata;
   logic [KEY_BITS-1:0]   rkey;
   logic [VALUE_BITS-1:0] rval;
   logic [XW-1:0]         n_x, l_x, r_x, idx_x;
   logic [AW-1:0]         parent;
   logic                  accept, out_free;

   // true when key a sits strictly above key b
   function automatic logic comes_first(input logic m, input logic [KEY_BITS-1:0] a,
                                        input logic [KEY_BITS-1:0] b);
      return m ? (a > b) : (a < b);
   endfunction

   bhpq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
   );

   assign rkey   = rdata[EW-1:VALUE_BITS];
   assign rval   = rdata[VALUE_BITS-1:0];
   assign n_x    = XW'(n_ff);
   assign l_x    = (XW'(pos_ff) << 1) + XW'(1);
   assign r_x    = l_x + XW'(1);
   assign idx_x  = XW'(req.index);
   assign parent = (pos_ff - AW'(1)) >> 1;

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign out_free  = !rvalid_ff || rsp.ready;

   // sequencer state and order mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         n_ff      <= '0;
         mode_ff   <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         n_ff      <= n_in;
         rvalid_ff <= rvalid_in;
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      pos_ff     <= pos_in;
      ekey_ff    <= ekey_in;
      eval_ff    <= eval_in;
      lkey_ff    <= lkey_in;
      lval_ff    <= lval_in;
      status_ff  <= status_in;
      pk_ff      <= pk_in;
      pv_ff      <= pv_in;
      rstatus_ff <= rstatus_in;
      rpk_ff     <= rpk_in;
      rpv_ff     <= rpv_in;
      rtk_ff     <= rtk_in;
      rtv_ff     <= rtv_in;
      rcnt_ff    <= rcnt_in;
      rempty_ff  <= rempty_in;
   end

   // next state, RAM control and response loading
   always_comb begin
      logic [KEY_BITS-1:0] bkey;
      logic [1:0]          bsel;
      state_in   = state_ff;
      n_in       = n_ff;
      pos_in     = pos_ff;
      ekey_in    = ekey_ff;
      eval_in    = eval_ff;
      lkey_in    = lkey_ff;
      lval_in    = lval_ff;
      status_in  = status_ff;
      pk_in      = pk_ff;
      pv_in      = pv_ff;
      rvalid_in  = rvalid_ff && !rsp.ready;
      rstatus_in = rstatus_ff;
      rpk_in     = rpk_ff;
      rpv_in     = rpv_ff;
      rtk_in     = rtk_ff;
      rtv_in     = rtv_ff;
      rcnt_in    = rcnt_ff;
      rempty_in  = rempty_ff;
      we         = 1'b0;
      waddr      = pos_ff;
      wdata      = {ekey_ff, eval_ff};
      raddr      = '0;
      bkey       = ekey_ff;
      bsel       = 2'd0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in = STAT_OK;
               pk_in     = '0;
               pv_in     = '0;
               ekey_in   = KEY_BITS'(req.key);
               eval_in   = VALUE_BITS'(req.value);
               state_in  = S_TOP;
               priority if (req.kind == KIND_INSERT) begin
                  if (n_x >= CAP_X) begin
                     status_in = STAT_FULL;
                  end else begin
                     pos_in   = AW'(n_ff);
                     n_in     = n_ff + CW'(1);
                     state_in = S_UP;
                  end
               end else if (req.kind == KIND_POP) begin
                  if (n_ff == '0) begin
                     status_in = STAT_EMPTY;
                  end else begin
                     state_in = S_POP_ROOT;
                  end
               end else if (req.kind == KIND_UPDATE) begin
                  if (idx_x >= n_x || idx_x >= CAP_X) begin
                     status_in = STAT_BAD_INDEX;
                  end else begin
                     raddr    = AW'(req.index);
                     pos_in   = AW'(req.index);
                     state_in = S_UPD;
                  end
               end else begin
                  // unused kind: no change, status ok
                  status_in = STAT_OK;
               end
            end
         end
         S_POP_ROOT: begin
            pk_in    = 32'(rkey);
            pv_in    = 32'(rval);
            raddr    = AW'(n_ff - CW'(1));
            state_in = S_POP_LAST;
         end
         S_POP_LAST: begin
            ekey_in  = rkey;
            eval_in  = rval;
            n_in     = n_ff - CW'(1);
            pos_in   = '0;
            state_in = S_DOWN;
         end
         S_UPD: begin
            eval_in  = rval;
            state_in = comes_first(mode_ff, rkey, ekey_ff) ? S_DOWN : S_UP;
         end
         S_UP: begin
            if (pos_ff == '0) begin
               we       = 1'b1;
               state_in = S_TOP;
            end else begin
               raddr    = parent;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            we = 1'b1;
            if (comes_first(mode_ff, ekey_ff, rkey)) begin
               wdata    = rdata;
               pos_in   = parent;
               state_in = S_UP;
            end else begin
               state_in = S_TOP;
            end
         end
         S_DOWN: begin
            if (l_x >= n_x) begin
               we       = 1'b1;
               state_in = S_TOP;
            end else begin
               raddr    = AW'(l_x);
               state_in = S_DOWN_L;
            end
         end
         S_DOWN_L: begin
            lkey_in = rkey;
            lval_in = rval;
            if (r_x < n_x) begin
               raddr = AW'(r_x);
            end
            state_in = S_DOWN_R;
         end
         S_DOWN_R: begin
            // left child first, so a tie between children keeps the left one
            if (comes_first(mode_ff, lkey_ff, bkey)) begin
               bkey = lkey_ff;
               bsel = 2'd1;
            end
            if (r_x < n_x && comes_first(mode_ff, rkey, bkey)) begin
               bsel = 2'd2;
            end
            we = 1'b1;
            if (bsel == 2'd1) begin
               wdata    = {lkey_ff, lval_ff};
               pos_in   = AW'(l_x);
               state_in = S_DOWN;
            end else if (bsel == 2'd2) begin
               wdata    = rdata;
               pos_in   = AW'(r_x);
               state_in = S_DOWN;
            end else begin
               state_in = S_TOP;
            end
         end
         S_TOP: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            // read address rests at the root, so the root data holds while stalled
            if (out_free) begin
               rvalid_in  = 1'b1;
               rstatus_in = status_ff;
               rpk_in     = pk_ff;
               rpv_in     = pv_ff;
               rtk_in     = (n_ff != '0) ? 32'(rkey) : '0;
               rtv_in     = (n_ff != '0) ? 32'(rval) : '0;
               rcnt_in    = 9'(n_ff);
               rempty_in  = (n_ff == '0);
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp.valid        = rvalid_ff;
   assign rsp.status       = rstatus_ff;
   assign rsp.popped_key   = rpk_ff;
   assign rsp.popped_value = rpv_ff;
   assign rsp.top_key      = rtk_ff;
   assign rsp.top_value    = rtv_ff;
   assign rsp.entry_count  = rcnt_ff;
   assign rsp.is_empty     = rempty_ff;
endmodule
